[rtl/psq_pkg.sv]
// Shared types and constants for the pitch scale quantizer.
// No dependencies; imported by every psq module.
`default_nettype none

package psq_pkg;

    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned NOTE_BITS   = 7;
    localparam int unsigned PITCH_BITS  = NOTE_BITS + FRAC_BITS;
    localparam int unsigned CLASS_COUNT = 12;
    localparam int unsigned CLASS_BITS  = 4;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_BITS   = 1;
    localparam int unsigned QCNT_BITS   = 2;

    // Classified word passed from the front end to the back end.
    typedef struct packed {
        logic [PITCH_BITS-1:0] pitch;
        logic                  mask_empty;
        logic                  have_low;
        logic [NOTE_BITS-1:0]  low_note;
        logic                  have_high;
        logic [NOTE_BITS-1:0]  high_note;
    } t_entry;

    // note mod 12 for note < 128: quotient by reciprocal 171/2048, then subtract.
    function automatic logic [CLASS_BITS-1:0] class_of(input logic [NOTE_BITS-1:0] note);
        logic [14:0]          prod;
        logic [3:0]           quo;
        logic [NOTE_BITS-1:0] rem;
        prod = 15'(note) * 15'(171);
        quo  = prod[14:11];
        rem  = note - 7'(7'(quo) * 7'(CLASS_COUNT));
        return rem[CLASS_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/pitch_scale_quantizer_top.sv]
// Top level of the pitch scale quantizer: front end, queue, back end.
// Depends on psq_pkg, psq_front, psq_queue, psq_back.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------
//  input    | i_valid / o_ready        | i_pitch_in[22:0] (7.16)
//  result   | o_valid / i_ready        | o_pitch_out[22:0], o_passed_through
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_data[11:0] scale mask
//
// One word per cycle sustained while i_ready stays high; an accepted word
// goes into the queue and then into the output register, raising o_valid.
// The two-word queue sets how long the input stays ready while the result
// side stalls. Synchronous active-low reset empties the queue and output
// register and clears the mask.
// Config is always ready; write it only while the block is idle.
`default_nettype none

module pitch_scale_quantizer_top import psq_pkg::*; #(
    parameter int unsigned TOP_NOTE = 127
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CLASS_COUNT-1:0] i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [PITCH_BITS-1:0]  i_pitch_in,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [PITCH_BITS-1:0]       o_pitch_out,
    output logic                        o_passed_through
);

    t_entry front_entry;
    t_entry queue_entry;
    logic   q_not_full;
    logic   q_not_empty;
    logic   q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = q_not_full;

    psq_front #(
        .TOP_NOTE (TOP_NOTE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_pitch     (i_pitch_in),
        .o_entry     (front_entry)
    );

    psq_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_valid && q_not_full),
        .i_entry     (front_entry),
        .i_pop       (q_pop),
        .o_not_full  (q_not_full),
        .o_not_empty (q_not_empty),
        .o_entry     (queue_entry)
    );

    psq_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_not_empty),
        .i_entry          (queue_entry),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pitch_out      (o_pitch_out),
        .o_passed_through (o_passed_through)
    );

endmodule

`default_nettype wire

[rtl/psq_front.sv]
// Front end: holds the scale mask and classifies each pitch into its
// nearest allowed lower and upper notes. Depends on psq_pkg.
`default_nettype none

module psq_front import psq_pkg::*; #(
    parameter int unsigned TOP_NOTE = 127
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CLASS_COUNT-1:0] i_cfg_data,
    input  wire logic [PITCH_BITS-1:0] i_pitch,
    output t_entry                     o_entry
);

    logic [CLASS_COUNT-1:0] r_scale_mask;
    logic [NOTE_BITS-1:0]   base;
    logic [CLASS_BITS-1:0]  cls;
    logic [CLASS_COUNT-1:0] lo_hit;
    logic [CLASS_COUNT-1:0] hi_hit;
    logic [CLASS_BITS-1:0]  lo_dist;
    logic [CLASS_BITS-1:0]  hi_dist;
    logic [4:0]             idx;
    logic [NOTE_BITS:0]     up_note;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_mask <= '0;
        end else if (i_cfg_valid) begin
            r_scale_mask <= i_cfg_data;
        end
    end

    assign base = i_pitch[PITCH_BITS-1:FRAC_BITS];
    assign cls  = class_of(base);

    // One candidate per step of the 12-note window on each side.
    always_comb begin
        lo_hit  = '0;
        hi_hit  = '0;
        idx     = '0;
        up_note = '0;
        for (int d = 0; d < CLASS_COUNT; d++) begin
            idx = 5'(cls) + 5'(CLASS_COUNT) - 5'(d);
            if (idx >= 5'(CLASS_COUNT)) begin
                idx = idx - 5'(CLASS_COUNT);
            end
            lo_hit[d] = r_scale_mask[idx[CLASS_BITS-1:0]] && (7'(d) <= base);

            idx = 5'(cls) + 5'(d + 1);
            if (idx >= 5'(CLASS_COUNT)) begin
                idx = idx - 5'(CLASS_COUNT);
            end
            up_note   = {1'b0, base} + 8'(d + 1);
            hi_hit[d] = r_scale_mask[idx[CLASS_BITS-1:0]] && (up_note <= 8'(TOP_NOTE));
        end
    end

    // Nearest hit wins: scan from far to near so the last write is the closest.
    always_comb begin
        lo_dist = '0;
        hi_dist = '0;
        for (int d = CLASS_COUNT - 1; d >= 0; d--) begin
            if (lo_hit[d]) begin
                lo_dist = CLASS_BITS'(d);
            end
            if (hi_hit[d]) begin
                hi_dist = CLASS_BITS'(d + 1);
            end
        end
    end

    always_comb begin
        o_entry.pitch      = i_pitch;
        o_entry.mask_empty = (r_scale_mask == '0);
        o_entry.have_low   = |lo_hit;
        o_entry.low_note   = base - 7'(lo_dist);
        o_entry.have_high  = |hi_hit;
        o_entry.high_note  = base + 7'(hi_dist);
    end

endmodule

`default_nettype wire

[rtl/psq_queue.sv]
// Two-word queue of classified entries between front and back end.
// Depends on psq_pkg.
`default_nettype none

module psq_queue import psq_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_not_full,
    output logic        o_not_empty,
    output t_entry      o_entry
);

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0]  r_count, n_count;

    assign o_not_full  = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_entry     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCNT_BITS'(i_push) - QCNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

[rtl/psq_back.sv]
// Back end: compares distances to the two candidates and holds the
// result in the output register. Depends on psq_pkg.
`default_nettype none

module psq_back import psq_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire t_entry                i_entry,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [PITCH_BITS-1:0]      o_pitch_out,
    output logic                       o_passed_through
);

    logic                  r_valid;
    logic [PITCH_BITS-1:0] r_pitch_out, n_pitch_out;
    logic                  r_passed, n_passed;
    logic [PITCH_BITS-1:0] low_pitch;
    logic [PITCH_BITS-1:0] high_pitch;
    logic [PITCH_BITS-1:0] dist_low;
    logic [PITCH_BITS-1:0] dist_high;

    assign o_pop = i_valid && (!r_valid || i_ready);

    assign low_pitch  = {i_entry.low_note, FRAC_BITS'(0)};
    assign high_pitch = {i_entry.high_note, FRAC_BITS'(0)};
    assign dist_low   = i_entry.pitch - low_pitch;
    assign dist_high  = high_pitch - i_entry.pitch;

    always_comb begin
        n_passed = 1'b0;
        if (i_entry.mask_empty) begin
            n_pitch_out = i_entry.pitch;
            n_passed    = 1'b1;
        end else if (i_entry.have_high && (!i_entry.have_low || dist_high < dist_low)) begin
            n_pitch_out = high_pitch;
        end else if (i_entry.have_low) begin
            n_pitch_out = low_pitch;
        end else begin
            n_pitch_out = i_entry.pitch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pitch_out <= n_pitch_out;
            r_passed    <= n_passed;
        end
    end

    assign o_valid          = r_valid;
    assign o_pitch_out      = r_pitch_out;
    assign o_passed_through = r_passed;

endmodule

`default_nettype wire

[rtl/psq_checker.sv]
// Port-level checks for the pitch scale quantizer, bound to the top level.
// Depends on psq_pkg and pitch_scale_quantizer_top.
`default_nettype none

module psq_checker import psq_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_valid,
    input wire logic                  i_ready,
    input wire logic [PITCH_BITS-1:0] o_pitch_out,
    input wire logic                  o_passed_through
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pitch_out)
                                && $stable(o_passed_through))
        else $error("result word changed while stalled");

    // A quantized note has no fraction bits.
    a_whole_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_passed_through |-> o_pitch_out[FRAC_BITS-1:0] == '0)
        else $error("quantized note carries a fraction");

    // Reset empties the output side.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind pitch_scale_quantizer_top psq_checker u_psq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_pitch_out      (o_pitch_out),
    .o_passed_through (o_passed_through)
);

`default_nettype wire
